// ===== rtl/core/hlt_pkg.sv =====
// shared constants, codes and controller/datapath interface types for the liveness table
package hlt_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int TIME_BITS   = 32;

   // field and register widths
   localparam int MODE_BITS     = 2;
   localparam int ID_BITS       = 16;
   localparam int KIND_BITS     = 2;
   localparam int STATUS_BITS   = 3;
   localparam int INTERVAL_BITS = 32;
   localparam int TTL_BITS      = 31;
   localparam int COUNT_BITS    = 32;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam int AGE_CMP_BITS  = (TIME_BITS > TTL_BITS) ? TIME_BITS : TTL_BITS;

   // register map
   localparam logic [CSR_IDX_BITS-1:0] CSR_SWEEP_PERIOD = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TTL          = 2'd1;

   localparam logic [INTERVAL_BITS-1:0] SWEEP_PERIOD_RESET = 32'd1000;
   localparam logic [TTL_BITS-1:0]      TTL_RESET          = 31'd5000;

   // input modes
   localparam logic [MODE_BITS-1:0] MODE_REGISTER  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_HEARTBEAT = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_TICK      = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_TERMINATE = 2'd3;

   // result kinds
   localparam logic [KIND_BITS-1:0] KIND_REPLY      = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_DISCONNECT = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_QUIET      = 2'd2;

   // status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK             = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_TERMINATED     = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_ALREADY_REG    = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_REGISTERED = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_TABLE_FULL     = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic accept;        // take the input word
      logic lookup_step;   // compare one entry against the id
      logic mark_step;     // age check one entry for the sweep
      logic count_clear;   // restart the sweep count
      logic commit_reply;  // apply register/heartbeat and load the reply
      logic emit_drop;     // drop the lowest marked entry and load its event
      logic emit_quiet;    // load a tick-with-nothing result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic stopped;
      logic sweep_due;
      logic walk_last;
      logic any_mark;
      logic one_mark;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/core/heartbeat_liveness_table.sv =====
// top level of the heartbeat liveness table: controller, datapath and checks
//
// Watches up to 16 channels, each an id plus the tick time of its last
// heartbeat. One input word is worked on at a time; req_stall stays high
// from acceptance until the word's last result has been loaded into the
// output register. A register or heartbeat word walks the table one entry
// per cycle to find the id and the lowest free slot, and skips the walk
// when the block is terminated; terminate goes straight to its reply. A
// tick that finds a sweep due on a running block age-checks all 16
// entries, one entry per cycle through a single subtract and compare, then
// loads one disconnect word per dropped channel. Disconnect words come out
// in table order, the final one marked with rsp_last; a tick that drops
// nothing gives one quiet word. Output stalls hold the block until the
// result register is free. The configuration registers (sweep period at
// index 0, ttl at index 1) should be written only while the block is idle.
module heartbeat_liveness_table import hlt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // input words
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [MODE_BITS-1:0]     req_mode,
   input  logic [ID_BITS-1:0]       req_bridge_id,
   // result words
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [KIND_BITS-1:0]     rsp_kind,
   output logic [STATUS_BITS-1:0]   rsp_status,
   output logic [ID_BITS-1:0]       rsp_lost_id,
   output logic                     rsp_last,
   // configuration writes
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   // sequencing: idle, table walks, sweep and result loading
   hlt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table, time base, config and output register
   hlt_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_mode      (req_mode),
      .req_bridge_id (req_bridge_id),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_kind      (rsp_kind),
      .rsp_status    (rsp_status),
      .rsp_lost_id   (rsp_lost_id),
      .rsp_last      (rsp_last),
      .cmd           (cmd),
      .stat          (stat)
   );

   // a word that is not the last of its item means the item is still running
   a_mid_item_stalls: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input taken while an item still has results to send");

   // replies and quiet ticks always close their item
   a_single_word_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_REPLY || rsp_kind == KIND_QUIET) |-> rsp_last)
      else $error("single-word result without last mark");

   // disconnect events carry ok status
   a_drop_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DISCONNECT |-> rsp_status == STATUS_OK)
      else $error("disconnect event with nonzero status");

   // only one result loaded per cycle, and only when the output can take it
   a_one_load: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit_reply || cmd.emit_drop || cmd.emit_quiet) |->
         $onehot({cmd.commit_reply, cmd.emit_drop, cmd.emit_quiet}) && stat.out_free)
      else $error("result load collision or overwrite of a held word");

endmodule

// ===== rtl/core/hlt_ctrl.sv =====
// sequencing state machine for the liveness table
module hlt_ctrl import hlt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [MODE_BITS-1:0] req_mode,
   output logic                 req_stall,
   input  stat_type             stat,
   output cmd_type              cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOKUP = 3'd1;
   localparam logic [2:0] S_REPLY  = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_MARK   = 3'd4;
   localparam logic [2:0] S_DROP   = 3'd5;
   localparam logic [2:0] S_QUIET  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_mode)
                  MODE_REGISTER, MODE_HEARTBEAT: begin
                     state_in = stat.stopped ? S_REPLY : S_LOOKUP;
                  end
                  MODE_TICK: begin
                     state_in = S_CHECK;
                  end
                  default: begin
                     state_in = S_REPLY;
                  end
               endcase
            end
         end
         S_LOOKUP: begin
            cmd.lookup_step = 1'b1;
            if (stat.walk_last) begin
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (stat.out_free) begin
               cmd.commit_reply = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CHECK: begin
            if (stat.stopped) begin
               state_in = S_QUIET;
            end else if (stat.sweep_due) begin
               cmd.count_clear = 1'b1;
               state_in = S_MARK;
            end else begin
               state_in = S_QUIET;
            end
         end
         S_MARK: begin
            cmd.mark_step = 1'b1;
            if (stat.walk_last) begin
               state_in = S_DROP;
            end
         end
         S_DROP: begin
            if (!stat.any_mark) begin
               state_in = S_QUIET;
            end else if (stat.out_free) begin
               cmd.emit_drop = 1'b1;
               if (stat.one_mark) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_QUIET: begin
            if (stat.out_free) begin
               cmd.emit_quiet = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/hlt_datapath.sv =====
// table storage, time counters, config registers and result register
module hlt_datapath import hlt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [MODE_BITS-1:0]     req_mode,
   input  logic [ID_BITS-1:0]       req_bridge_id,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic [KIND_BITS-1:0]     rsp_kind,
   output logic [STATUS_BITS-1:0]   rsp_status,
   output logic [ID_BITS-1:0]       rsp_lost_id,
   output logic                     rsp_last,
   input  cmd_type                  cmd,
   output stat_type                 stat
);

   // latched input word
   logic [MODE_BITS-1:0] mode_ff;
   logic [ID_BITS-1:0]   id_ff;

   // table
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [TABLE_DEPTH-1:0] mark_ff, mark_in;
   logic [ID_BITS-1:0]     ent_id_ff   [TABLE_DEPTH];
   logic [TIME_BITS-1:0]   ent_time_ff [TABLE_DEPTH];

   // walk and lookup results
   logic [IDX_BITS-1:0] walk_idx_ff, walk_idx_in;
   logic                found_ff, found_in;
   logic [IDX_BITS-1:0] found_idx_ff, found_idx_in;
   logic                free_ff, free_in;
   logic [IDX_BITS-1:0] free_idx_ff, free_idx_in;

   // time and control
   logic [TIME_BITS-1:0]     tick_ff, tick_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic                     stopped_ff, stopped_in;
   logic [INTERVAL_BITS-1:0] interval_ff, interval_in;
   logic [TTL_BITS-1:0]      ttl_ff, ttl_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [KIND_BITS-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]     rsp_lost_id_ff, rsp_lost_id_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   out_free;
   logic [TIME_BITS-1:0]   walk_age;
   logic                   walk_hit;
   logic                   walk_match;
   logic [IDX_BITS-1:0]    drop_idx;
   logic [TABLE_DEPTH-1:0] drop_bit;
   logic                   is_lookup_mode;
   logic                   reg_ok;
   logic                   hb_ok;
   logic [STATUS_BITS-1:0] reply_status;
   logic                   ent_wr_en;
   logic                   ent_wr_id;
   logic [IDX_BITS-1:0]    ent_wr_idx;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // one entry per cycle at the walk index
   assign walk_age   = tick_ff - ent_time_ff[walk_idx_ff];
   assign walk_hit   = valid_ff[walk_idx_ff] &&
                       (AGE_CMP_BITS'(walk_age) >= AGE_CMP_BITS'(ttl_ff));
   assign walk_match = valid_ff[walk_idx_ff] && (ent_id_ff[walk_idx_ff] == id_ff);

   // lowest marked entry
   always_comb begin
      drop_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (mark_ff[i]) begin
            drop_idx = IDX_BITS'(i);
         end
      end
   end
   assign drop_bit = TABLE_DEPTH'(1) << drop_idx;

   assign is_lookup_mode = mode_ff inside {MODE_REGISTER, MODE_HEARTBEAT};
   assign reg_ok = (mode_ff == MODE_REGISTER) && !stopped_ff && !found_ff && free_ff;
   assign hb_ok  = (mode_ff == MODE_HEARTBEAT) && !stopped_ff && found_ff;

   always_comb begin
      reply_status = STATUS_OK;
      if (is_lookup_mode && stopped_ff) begin
         reply_status = STATUS_TERMINATED;
      end else if (mode_ff == MODE_REGISTER) begin
         if (found_ff) begin
            reply_status = STATUS_ALREADY_REG;
         end else if (!free_ff) begin
            reply_status = STATUS_TABLE_FULL;
         end
      end else if (mode_ff == MODE_HEARTBEAT) begin
         if (!found_ff) begin
            reply_status = STATUS_NOT_REGISTERED;
         end
      end
   end

   assign ent_wr_en  = cmd.commit_reply && (reg_ok || hb_ok);
   assign ent_wr_id  = reg_ok;
   assign ent_wr_idx = reg_ok ? free_idx_ff : found_idx_ff;

   always_comb begin
      valid_in     = valid_ff;
      mark_in      = mark_ff;
      walk_idx_in  = walk_idx_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      tick_in      = tick_ff;
      count_in     = count_ff;
      stopped_in   = stopped_ff;
      interval_in  = interval_ff;
      ttl_in       = ttl_ff;

      if (csr_wr_en) begin
         if (csr_index == CSR_SWEEP_PERIOD) begin
            interval_in = csr_wdata[INTERVAL_BITS-1:0];
         end else if (csr_index == CSR_TTL) begin
            ttl_in = csr_wdata[TTL_BITS-1:0];
         end
      end

      if (cmd.accept) begin
         walk_idx_in = '0;
         found_in    = 1'b0;
         free_in     = 1'b0;
         if (req_mode == MODE_TICK) begin
            tick_in = tick_ff + TIME_BITS'(1);
            if (!stopped_ff) begin
               count_in = count_ff + COUNT_BITS'(1);
            end
         end
         if (req_mode == MODE_TERMINATE) begin
            stopped_in = 1'b1;
         end
      end

      if (cmd.count_clear) begin
         count_in = '0;
      end

      if (cmd.lookup_step || cmd.mark_step) begin
         walk_idx_in = walk_idx_ff + IDX_BITS'(1);
      end

      if (cmd.lookup_step) begin
         if (walk_match && !found_ff) begin
            found_in     = 1'b1;
            found_idx_in = walk_idx_ff;
         end
         if (!valid_ff[walk_idx_ff] && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = walk_idx_ff;
         end
      end

      if (cmd.mark_step) begin
         mark_in[walk_idx_ff] = walk_hit;
      end

      if (cmd.commit_reply && reg_ok) begin
         valid_in[free_idx_ff] = 1'b1;
      end

      if (cmd.emit_drop) begin
         valid_in = valid_ff & ~drop_bit;
         mark_in  = mark_ff & ~drop_bit;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_kind_in    = rsp_kind_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_lost_id_in = rsp_lost_id_ff;
      rsp_last_in    = rsp_last_ff;
      if (cmd.commit_reply) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = KIND_REPLY;
         rsp_status_in  = reply_status;
         rsp_lost_id_in = '0;
         rsp_last_in    = 1'b1;
      end else if (cmd.emit_drop) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = KIND_DISCONNECT;
         rsp_status_in  = STATUS_OK;
         rsp_lost_id_in = ent_id_ff[drop_idx];
         rsp_last_in    = ((mark_ff & ~drop_bit) == '0);
      end else if (cmd.emit_quiet) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = KIND_QUIET;
         rsp_status_in  = stopped_ff ? STATUS_TERMINATED : STATUS_OK;
         rsp_lost_id_in = '0;
         rsp_last_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         mark_ff      <= '0;
         walk_idx_ff  <= '0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         tick_ff      <= '0;
         count_ff     <= '0;
         stopped_ff   <= 1'b0;
         interval_ff  <= SWEEP_PERIOD_RESET;
         ttl_ff       <= TTL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         mark_ff      <= mark_in;
         walk_idx_ff  <= walk_idx_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         tick_ff      <= tick_in;
         count_ff     <= count_in;
         stopped_ff   <= stopped_in;
         interval_ff  <= interval_in;
         ttl_ff       <= ttl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= req_mode;
         id_ff   <= req_bridge_id;
      end
      found_idx_ff   <= found_idx_in;
      free_idx_ff    <= free_idx_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_lost_id_ff <= rsp_lost_id_in;
      rsp_last_ff    <= rsp_last_in;
      if (ent_wr_en) begin
         ent_time_ff[ent_wr_idx] <= tick_ff;
         if (ent_wr_id) begin
            ent_id_ff[ent_wr_idx] <= id_ff;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_lost_id = rsp_lost_id_ff;
   assign rsp_last    = rsp_last_ff;

   assign stat.stopped   = stopped_ff;
   assign stat.sweep_due = (count_ff >= interval_ff);
   assign stat.walk_last = (walk_idx_ff == IDX_BITS'(TABLE_DEPTH - 1));
   assign stat.any_mark  = (mark_ff != '0);
   assign stat.one_mark  = ((mark_ff & ~drop_bit) == '0);
   assign stat.out_free  = out_free;

endmodule

// ===== tb/sv/liveness_checker.sv =====
// checker for the liveness table: shadow table, result prediction and compare
`timescale 1ns / 100ps

module liveness_checker import hlt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [MODE_BITS-1:0]     req_mode,
   input  logic [ID_BITS-1:0]       req_bridge_id,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [KIND_BITS-1:0]     rsp_kind,
   input  logic [STATUS_BITS-1:0]   rsp_status,
   input  logic [ID_BITS-1:0]       rsp_lost_id,
   input  logic                     rsp_last,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int                       mismatch_total,
   output int                       results_owed,
   output int                       results_checked,
   output int                       drops_checked
);

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic [STATUS_BITS-1:0] status;
      logic [ID_BITS-1:0]     lost_id;
      logic                   last;
   } result_word_type;

   // shadow of the watched-channel table
   logic                   slot_used [TABLE_DEPTH];
   logic [ID_BITS-1:0]     slot_id   [TABLE_DEPTH];
   logic [TIME_BITS-1:0]   slot_seen [TABLE_DEPTH];
   logic [TIME_BITS-1:0]   now_tick;
   logic [COUNT_BITS-1:0]  sweep_count;
   logic                   halted;
   logic [INTERVAL_BITS-1:0] cfg_interval;
   logic [TTL_BITS-1:0]    cfg_ttl;

   result_word_type owed_results[$];
   result_word_type got, want;
   int mismatches, checked, drops;

   function automatic result_word_type make_word(
      input logic [KIND_BITS-1:0]   kind,
      input logic [STATUS_BITS-1:0] status,
      input logic [ID_BITS-1:0]     lost_id,
      input logic                   last);
      result_word_type w;
      w.kind    = kind;
      w.status  = status;
      w.lost_id = lost_id;
      w.last    = last;
      return w;
   endfunction

   // apply one accepted input word to the shadow table and queue what it owes
   task automatic advance_table(input logic [MODE_BITS-1:0] mode,
                                input logic [ID_BITS-1:0] id);
      int hit;
      int free_slot;
      int dropped;
      logic [TIME_BITS-1:0] age;
      logic [STATUS_BITS-1:0] status;
      result_word_type w;
      hit       = -1;
      free_slot = -1;
      dropped   = 0;
      status    = STATUS_OK;
      case (mode)
         MODE_REGISTER, MODE_HEARTBEAT: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_used[i] && slot_id[i] == id && hit < 0) hit = i;
               if (!slot_used[i] && free_slot < 0) free_slot = i;
            end
            if (halted) begin
               status = STATUS_TERMINATED;
            end else if (mode == MODE_REGISTER) begin
               if (hit >= 0) status = STATUS_ALREADY_REG;
               else if (free_slot < 0) status = STATUS_TABLE_FULL;
               else begin
                  slot_used[free_slot] = 1'b1;
                  slot_id[free_slot]   = id;
                  slot_seen[free_slot] = now_tick;
               end
            end else if (hit < 0) begin
               status = STATUS_NOT_REGISTERED;
            end else begin
               slot_seen[hit] = now_tick;
            end
            owed_results.push_back(make_word(KIND_REPLY, status, '0, 1'b1));
         end
         MODE_TERMINATE: begin
            halted = 1'b1;
            owed_results.push_back(make_word(KIND_REPLY, STATUS_OK, '0, 1'b1));
         end
         default: begin
            now_tick = now_tick + 1'b1;
            if (halted) begin
               owed_results.push_back(make_word(KIND_QUIET, STATUS_TERMINATED, '0, 1'b1));
            end else begin
               sweep_count = sweep_count + 1'b1;
               if (sweep_count >= cfg_interval) begin
                  sweep_count = '0;
                  for (int i = 0; i < TABLE_DEPTH; i++) begin
                     if (slot_used[i]) begin
                        age = now_tick - slot_seen[i];
                        if (age >= cfg_ttl) begin
                           slot_used[i] = 1'b0;
                           owed_results.push_back(make_word(KIND_DISCONNECT, STATUS_OK,
                                                            slot_id[i], 1'b0));
                           dropped++;
                        end
                     end
                  end
               end
               if (dropped == 0) begin
                  owed_results.push_back(make_word(KIND_QUIET, STATUS_OK, '0, 1'b1));
               end else begin
                  // the final disconnect of the sweep carries last
                  w = owed_results.pop_back();
                  w.last = 1'b1;
                  owed_results.push_back(w);
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
         now_tick     = '0;
         sweep_count  = '0;
         halted       = 1'b0;
         cfg_interval = SWEEP_PERIOD_RESET;
         cfg_ttl      = TTL_RESET;
         owed_results.delete();
         mismatches   = 0;
         checked      = 0;
         drops        = 0;
      end else begin
         // indexes past the register map are ignored
         if (csr_wr_en) begin
            if (csr_index == CSR_SWEEP_PERIOD) cfg_interval = csr_wdata;
            else if (csr_index == CSR_TTL) cfg_ttl = csr_wdata[TTL_BITS-1:0];
         end
         // compare before predicting, a word cannot answer itself in its own cycle
         if (rsp_valid && !rsp_stall) begin
            got = make_word(rsp_kind, rsp_status, rsp_lost_id, rsp_last);
            checked++;
            if (got.kind == KIND_DISCONNECT) drops++;
            if (owed_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display(
                     "mismatch at %0t: unexpected word kind %0d status %0d lost_id %h last %0d",
                     $time, got.kind, got.status, got.lost_id, got.last);
            end else begin
               want = owed_results.pop_front();
               if (got.kind != want.kind || got.status != want.status ||
                   got.lost_id != want.lost_id || got.last != want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch at %0t: expected kind %0d status %0d lost_id %h",
                               " last %0d, got kind %0d status %0d lost_id %h last %0d"},
                              $time, want.kind, want.status, want.lost_id, want.last,
                              got.kind, got.status, got.lost_id, got.last);
               end
            end
         end
         if (req_valid && !req_stall) advance_table(req_mode, req_bridge_id);
      end
      mismatch_total  <= mismatches;
      results_owed    <= owed_results.size();
      results_checked <= checked;
      drops_checked   <= drops;
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// top of the liveness table bench: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module tb_top;
   import hlt_pkg::*;

   localparam int POOL_SIZE   = 20;
   localparam int STUCK_LIMIT = 4000;   // cycles with no handshake before giving up
   localparam int HOLD_CYCLES = 300;    // long receiver hold-off to back the block up
   localparam int TAIL_CYCLES = 40;

   // unmapped register indexes, writes there must be ignored
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_B = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [MODE_BITS-1:0]     req_mode = MODE_TICK;
   logic [ID_BITS-1:0]       req_bridge_id = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [KIND_BITS-1:0]     rsp_kind;
   logic [STATUS_BITS-1:0]   rsp_status;
   logic [ID_BITS-1:0]       rsp_lost_id;
   logic                     rsp_last;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_SWEEP_PERIOD;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int mismatch_total, results_owed, results_checked, drops_checked;

   // stimulus side knobs
   bit   tx_quiet = 1'b0;          // sender offers back to back
   logic rx_quiet = 1'b0;          // receiver never stalls
   int   hold_token = 0;           // bump to start one long receiver hold-off
   int   words_sent [4];
   int   settings_used = 0;
   logic [ID_BITS-1:0] id_pool [POOL_SIZE];

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   heartbeat_liveness_table u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_bridge_id (req_bridge_id),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_status    (rsp_status),
      .rsp_lost_id   (rsp_lost_id),
      .rsp_last      (rsp_last),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   liveness_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_bridge_id   (req_bridge_id),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_status      (rsp_status),
      .rsp_lost_id     (rsp_lost_id),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_total  (mismatch_total),
      .results_owed    (results_owed),
      .results_checked (results_checked),
      .drops_checked   (drops_checked)
   );

   // receiver: after each taken word it draws a random stall unless rx_quiet is set,
   // and on request holds off for a long stretch counted here
   int rx_wait = 0;
   int rx_hold = 0;
   int hold_seen = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            rx_hold   = HOLD_CYCLES;
         end
         if (rx_hold > 0) rx_hold--;
         else if (rsp_valid && !rsp_stall) rx_wait = rx_quiet ? 0 : $urandom_range(0, 16);
         else if (rx_wait > 0) rx_wait--;
         rsp_stall <= (rx_hold > 0) || (rx_wait > 0);
      end
   end

   // watchdog on forward progress of any channel
   int stuck_cycles = 0;

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results still owed",
                  stuck_cycles, results_owed);
         $display("heartbeat_liveness_table test failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // offer one word after a random gap and wait for it to be taken;
   // valid stays high across back-to-back words
   task automatic send_word(input logic [MODE_BITS-1:0] mode, input logic [ID_BITS-1:0] id);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_bridge_id <= id;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent[mode]++;
   endtask

   // mostly ids from a small pool so duplicates, refreshes and a full table happen,
   // the rest any 16-bit value or the extremes
   function automatic logic [ID_BITS-1:0] pick_id();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 85) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (roll < 95) return ID_BITS'($urandom);
      else if (roll < 98) return '0;
      else return '1;
   endfunction

   task automatic send_random(input bit allow_stop);
      int roll;
      logic [MODE_BITS-1:0] mode;
      roll = $urandom_range(0, 99);
      if (allow_stop && roll < 8) mode = MODE_TERMINATE;
      else if (roll < 38) mode = MODE_REGISTER;
      else if (roll < 68) mode = MODE_HEARTBEAT;
      else mode = MODE_TICK;
      send_word(mode, pick_id());
   endtask

   // wait until every owed word has come back and the block is idle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write both registers and one unmapped index, only while idle
   task automatic apply_setting(input logic [CSR_DATA_BITS-1:0] interval,
                                input logic [CSR_DATA_BITS-1:0] ttl_word);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SWEEP_PERIOD;
      csr_wdata <= interval;
      @(posedge clock);
      csr_index <= CSR_TTL;
      csr_wdata <= ttl_word;
      @(posedge clock);
      csr_index <= ($urandom_range(0, 1) != 0) ? CSR_SPARE_A : CSR_SPARE_B;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   logic [CSR_DATA_BITS-1:0] phase_interval [6];
   logic [CSR_DATA_BITS-1:0] phase_ttl [6];

   initial begin
      foreach (words_sent[m]) words_sent[m] = 0;
      foreach (id_pool[k]) id_pool[k] = ID_BITS'($urandom);

      // settings for the random phases: tight sweeps, max values,
      // zero interval, a random pair, and a ttl with bit 31 set that must be masked
      phase_interval[0] = 32'd1;           phase_ttl[0] = 32'd4;
      phase_interval[1] = 32'd3;           phase_ttl[1] = 32'd8;
      phase_interval[2] = 32'hFFFF_FFFF;   phase_ttl[2] = 32'h7FFF_FFFF;
      phase_interval[3] = 32'd0;           phase_ttl[3] = 32'd1;
      phase_interval[4] = $urandom_range(1, 5);
      phase_ttl[4]      = $urandom_range(1, 12);
      phase_interval[5] = 32'd2;           phase_ttl[5] = 32'h8000_0006;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (3) @(posedge clock);

      // directed: replies with every status but terminated, a sweep that drops one channel,
      // a full table, then a zero interval with zero ttl that drops all 16
      apply_setting(32'd2, 32'd3);
      send_word(MODE_HEARTBEAT, 16'h0005);      // unknown id
      send_word(MODE_REGISTER, 16'h0000);
      send_word(MODE_REGISTER, 16'hFFFF);
      send_word(MODE_REGISTER, 16'h0000);       // already present
      send_word(MODE_HEARTBEAT, 16'hFFFF);
      send_word(MODE_TICK, 16'h0000);
      send_word(MODE_TICK, 16'hFFFF);           // sweep, nothing old enough
      send_word(MODE_HEARTBEAT, 16'h0000);
      send_word(MODE_TICK, 16'h0000);
      send_word(MODE_TICK, 16'h0000);           // sweep drops the stale channel
      for (int k = 1; k < TABLE_DEPTH; k++) send_word(MODE_REGISTER, ID_BITS'(k));
      send_word(MODE_REGISTER, 16'hA5A5);       // no free entry left
      drain();
      apply_setting(32'd0, 32'd0);
      send_word(MODE_TICK, 16'h5A5A);           // sweep on every tick, everything expires
      drain();

      // random phases, one setting each; some run with no idling on either side,
      // and the second one starts with a long receiver hold-off
      for (int p = 0; p < 6; p++) begin
         apply_setting(phase_interval[p], phase_ttl[p]);
         tx_quiet = (p % 3 == 1);
         rx_quiet <= (p % 3 == 1);
         if (p == 1) hold_token <= hold_token + 1;
         repeat (22) send_random(1'b0);
         drain();
      end

      // last phase: monitoring gets stopped, and everything after that but a further terminate is refused
      apply_setting(32'd1, 32'd2);
      tx_quiet = 1'b0;
      rx_quiet <= 1'b0;
      repeat (12) send_random(1'b0);
      send_word(MODE_TERMINATE, pick_id());
      repeat (10) send_random(1'b1);
      send_word(MODE_TERMINATE, pick_id());     // stopping twice is still ok
      send_word(MODE_TICK, pick_id());
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display({"run covered %0d words (%0d register, %0d heartbeat, %0d tick,",
                " %0d terminate) under %0d settings"},
               words_sent[MODE_REGISTER] + words_sent[MODE_HEARTBEAT] +
               words_sent[MODE_TICK] + words_sent[MODE_TERMINATE],
               words_sent[MODE_REGISTER], words_sent[MODE_HEARTBEAT],
               words_sent[MODE_TICK], words_sent[MODE_TERMINATE], settings_used);
      $display("%0d result words checked, %0d disconnects, %0d mismatches",
               results_checked, drops_checked, mismatch_total);
      if (mismatch_total == 0 && results_owed == 0) begin
         $display("heartbeat_liveness_table test passed");
      end else begin
         $display("heartbeat_liveness_table test failed");
      end
      $finish;
   end

endmodule
